// ===== hdl/cbd_pkg.sv =====
// ----------------------------------------------------------------------------
// cbd_pkg
// Types and constants shared by the console CPU bus decoder: item layouts,
// command and target codes, and the address map boundaries.
// ----------------------------------------------------------------------------
package cbd_pkg;

  localparam int RAM_WORDS_DEF = 2048;

  // commands
  localparam logic [2:0] CMD_READ  = 3'd0;
  localparam logic [2:0] CMD_WRITE = 3'd1;
  localparam logic [2:0] CMD_PUSH  = 3'd2;
  localparam logic [2:0] CMD_POP   = 3'd3;
  localparam logic [2:0] CMD_LDSP  = 3'd4;

  // targets
  localparam logic [3:0] TGT_RAM      = 4'd0;
  localparam logic [3:0] TGT_PPU      = 4'd1;
  localparam logic [3:0] TGT_CTRL1    = 4'd2;
  localparam logic [3:0] TGT_CTRL2    = 4'd3;
  localparam logic [3:0] TGT_DMA      = 4'd4;
  localparam logic [3:0] TGT_APU      = 4'd5;
  localparam logic [3:0] TGT_APUST    = 4'd6;
  localparam logic [3:0] TGT_MAPPER   = 4'd7;
  localparam logic [3:0] TGT_TESTERR  = 4'd8;
  localparam logic [3:0] TGT_UNMAPPED = 4'd9;

  // address map
  localparam logic [15:0] ADDR_RAM_END    = 16'h1FFF;
  localparam logic [15:0] ADDR_PPU_BASE   = 16'h2000;
  localparam logic [15:0] ADDR_PPU_END    = 16'h3FFF;
  localparam logic [15:0] ADDR_DMA        = 16'h4014;
  localparam logic [15:0] ADDR_APU_STATUS = 16'h4015;
  localparam logic [15:0] ADDR_CTRL1      = 16'h4016;
  localparam logic [15:0] ADDR_CTRL2      = 16'h4017;
  localparam logic [15:0] ADDR_TEST_BASE  = 16'h4018;
  localparam logic [15:0] ADDR_TEST_END   = 16'h401F;
  localparam logic [15:0] ADDR_MAPPER     = 16'h4020;
  localparam logic [7:0]  STACK_PAGE      = 8'h01;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [7:0]  buttons;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  target;
    logic [7:0]  read_data;
    logic [15:0] fwd_addr;
    logic [7:0]  fwd_data;
    logic        fwd_write;
    logic        dma_start;
    logic [15:0] dma_base;
    logic [7:0]  stack_ptr;
  } out_item_t;

endpackage

// ===== hdl/console_cpu_bus_decoder.sv =====
// ----------------------------------------------------------------------------
// console_cpu_bus_decoder
// Decodes one CPU bus access per item against the console memory map, keeps
// the mirrored work RAM, the first controller shift register and the stack
// pointer, and reports the target with the address and data to forward.
//
//   channel | ports                     | handshake
//   --------+---------------------------+-------------------------------
//   input   | start, busy, in_item      | taken when start && !busy
//   result  | out_valid, out_item       | one-cycle strobe, no back-pressure
//
// An item's result appears in the cycle after it is taken; the work RAM read
// is registered alongside it. busy stays low, so one item a cycle is
// taken: state updates land at the accept edge and the next item sees them.
// Synchronous active-low reset clears the stack pointer, the controller
// register and the result strobe; the RAM is not cleared.
// RAM_WORDS must be a power of two.
// ----------------------------------------------------------------------------
module console_cpu_bus_decoder #(
  parameter int RAM_WORDS = cbd_pkg::RAM_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cbd_pkg::in_item_t in_item,
  output logic              out_valid,
  output cbd_pkg::out_item_t out_item
);

  localparam int AW = $clog2(RAM_WORDS);

  logic [7:0]          mem [RAM_WORDS];
  logic [7:0]          ram_q_r;
  logic                rd_ram_r;
  logic                out_valid_r;
  cbd_pkg::out_item_t  out_r;
  logic [7:0]          sp_r, sp_nxt;
  logic [7:0]          pad_r, pad_nxt;

  logic                acc;
  logic                do_bus, bus_wr;
  logic [15:0]         bus_addr;
  logic [7:0]          bus_d, sp_inc;
  logic                ram_we, ram_re;
  cbd_pkg::out_item_t  res;

  assign busy = 1'b0;
  assign acc  = start && !busy;
  assign sp_inc = sp_r + 8'd1;

  always_comb begin
    do_bus   = 1'b0;
    bus_wr   = 1'b0;
    bus_addr = in_item.addr;
    bus_d    = in_item.data;
    sp_nxt   = sp_r;
    pad_nxt  = pad_r;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    res      = '0;
    res.target = cbd_pkg::TGT_UNMAPPED;

    case (in_item.cmd)
      cbd_pkg::CMD_READ: begin
        do_bus = 1'b1;
      end
      cbd_pkg::CMD_WRITE: begin
        do_bus = 1'b1;
        bus_wr = 1'b1;
      end
      cbd_pkg::CMD_PUSH: begin
        do_bus   = 1'b1;
        bus_wr   = 1'b1;
        bus_addr = {cbd_pkg::STACK_PAGE, sp_r};
        sp_nxt   = sp_r - 8'd1;
      end
      cbd_pkg::CMD_POP: begin
        do_bus   = 1'b1;
        bus_addr = {cbd_pkg::STACK_PAGE, sp_inc};
        sp_nxt   = sp_inc;
      end
      cbd_pkg::CMD_LDSP: begin
        sp_nxt = in_item.data;
      end
      default: begin
      end
    endcase

    if (do_bus) begin
      if (bus_addr <= cbd_pkg::ADDR_RAM_END) begin
        res.target = cbd_pkg::TGT_RAM;
        ram_we = bus_wr;
        ram_re = !bus_wr;
      end else if (bus_addr inside {[cbd_pkg::ADDR_PPU_BASE:cbd_pkg::ADDR_PPU_END]}) begin
        res.target    = cbd_pkg::TGT_PPU;
        res.fwd_addr  = {13'd0, bus_addr[2:0]};
        res.fwd_write = bus_wr;
        res.fwd_data  = bus_wr ? bus_d : 8'd0;
      end else if (bus_addr == cbd_pkg::ADDR_CTRL1) begin
        res.target = cbd_pkg::TGT_CTRL1;
        if (bus_wr) begin
          if (bus_d[0]) pad_nxt = in_item.buttons;
        end else begin
          res.read_data = {7'd0, pad_r[0]};
          pad_nxt = {1'b0, pad_r[7:1]};
        end
      end else if (bus_wr) begin
        if (bus_addr == cbd_pkg::ADDR_DMA) begin
          res.target    = cbd_pkg::TGT_DMA;
          res.dma_start = 1'b1;
          res.dma_base  = {bus_d, 8'd0};
        end else if (bus_addr <= cbd_pkg::ADDR_CTRL2) begin
          res.target    = cbd_pkg::TGT_APU;
          res.fwd_addr  = bus_addr;
          res.fwd_data  = bus_d;
          res.fwd_write = 1'b1;
        end else if (bus_addr >= cbd_pkg::ADDR_MAPPER) begin
          res.target    = cbd_pkg::TGT_MAPPER;
          res.fwd_addr  = bus_addr;
          res.fwd_data  = bus_d;
          res.fwd_write = 1'b1;
        end
      end else begin
        if (bus_addr == cbd_pkg::ADDR_CTRL2) begin
          res.target = cbd_pkg::TGT_CTRL2;
        end else if (bus_addr == cbd_pkg::ADDR_APU_STATUS) begin
          res.target   = cbd_pkg::TGT_APUST;
          res.fwd_addr = bus_addr;
        end else if (bus_addr inside {[cbd_pkg::ADDR_TEST_BASE:cbd_pkg::ADDR_TEST_END]}) begin
          res.target = cbd_pkg::TGT_TESTERR;
        end else if (bus_addr >= cbd_pkg::ADDR_MAPPER) begin
          res.target   = cbd_pkg::TGT_MAPPER;
          res.fwd_addr = bus_addr;
        end
      end
    end

    res.stack_ptr = sp_nxt;
  end

  // work ram, one port, registered read
  always_ff @(posedge clk) begin
    if (acc && ram_we) mem[bus_addr[AW-1:0]] <= bus_d;
    if (acc && ram_re) ram_q_r <= mem[bus_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r        <= '0;
      pad_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= acc;
      if (acc) begin
        sp_r  <= sp_nxt;
        pad_r <= pad_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_r    <= res;
      rd_ram_r <= ram_re;
    end
  end

  always_comb begin
    out_item = out_r;
    if (rd_ram_r) out_item.read_data = ram_q_r;
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_strobe_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("result strobe missing after accepted item");

  a_dma_target: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.dma_start) |-> (out_item.target == cbd_pkg::TGT_DMA))
    else $error("dma request outside dma target");

  a_ctrl_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.target == cbd_pkg::TGT_CTRL1) |-> (out_item.read_data[7:1] == 7'd0))
    else $error("controller read wider than one bit");

  a_push_sp: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.cmd == cbd_pkg::CMD_PUSH)
      |=> (out_item.stack_ptr == $past(sp_r) - 8'd1))
    else $error("push did not decrement stack pointer");
`endif

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the console CPU bus decoder. A queue of bus items
// (directed corner cases, then random RAM traffic, stack push/pop runs,
// controller strobe-and-shift sequences, stray addresses and noise) feeds a
// clocked driver with random gaps. A predictor tracks work RAM, controller
// shift register and stack pointer, and a monitor checks every result strobe
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import cbd_pkg::*;

  localparam int RAM_WORDS = RAM_WORDS_DEF;
  localparam int ITEM_COUNT = 1950;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [2:0] CMD_SPARE_LAST = 3'd7;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  in_item_t in_item = '0;
  logic busy;
  logic out_valid;
  out_item_t out_item;

  // stimulus-side view of which RAM entries hold data
  bit gen_written [RAM_WORDS];
  logic [7:0] gen_sp = '0;
  logic [10:0] recent_idx [16] = '{default: '0};
  int recent_ptr = 0;
  int bus_items = 0;

  // predictor state
  logic [7:0] ram_img [RAM_WORDS];
  logic [7:0] pad_img = '0;
  logic [7:0] sp_img = '0;

  in_item_t pending_accesses [$];
  out_item_t predicted_results [$];

  int mismatches = 0;
  int results_seen = 0;
  int ram_results = 0;
  int pad_results = 0;
  int cycles = 0;
  int gap_left = 0;
  bit no_gaps = 1'b0;

  console_cpu_bus_decoder DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_item(out_item)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic out_item_t decode_access(logic [15:0] a, bit wr, logic [7:0] d,
                                              logic [7:0] btn);
    out_item_t r;
    r = '0;
    r.target = TGT_UNMAPPED;
    if (a <= ADDR_RAM_END) begin
      r.target = TGT_RAM;
      if (wr) begin
        ram_img[a % RAM_WORDS] = d;
      end else begin
        r.read_data = ram_img[a % RAM_WORDS];
      end
    end else if (a <= ADDR_PPU_END) begin
      r.target = TGT_PPU;
      r.fwd_addr = {13'd0, a[2:0]};
      r.fwd_write = wr;
      r.fwd_data = wr ? d : 8'h00;
    end else if (a == ADDR_CTRL1) begin
      r.target = TGT_CTRL1;
      if (wr) begin
        if (d[0]) pad_img = btn;
      end else begin
        r.read_data = {7'd0, pad_img[0]};
        pad_img = pad_img >> 1;
      end
    end else if (wr) begin
      if (a == ADDR_DMA) begin
        r.target = TGT_DMA;
        r.dma_start = 1'b1;
        r.dma_base = {d, 8'h00};
      end else if (a <= ADDR_CTRL2 || a >= ADDR_MAPPER) begin
        r.target = (a >= ADDR_MAPPER) ? TGT_MAPPER : TGT_APU;
        r.fwd_addr = a;
        r.fwd_data = d;
        r.fwd_write = 1'b1;
      end
    end else begin
      if (a == ADDR_CTRL2) begin
        r.target = TGT_CTRL2;
      end else if (a == ADDR_APU_STATUS) begin
        r.target = TGT_APUST;
        r.fwd_addr = a;
      end else if (a >= ADDR_TEST_BASE && a <= ADDR_TEST_END) begin
        r.target = TGT_TESTERR;
      end else if (a >= ADDR_MAPPER) begin
        r.target = TGT_MAPPER;
        r.fwd_addr = a;
      end
    end
    return r;
  endfunction

  function automatic out_item_t predict_bus_access(in_item_t it);
    out_item_t r;
    r = '0;
    r.target = TGT_UNMAPPED;
    case (it.cmd)
      CMD_READ:  r = decode_access(it.addr, 1'b0, it.data, it.buttons);
      CMD_WRITE: r = decode_access(it.addr, 1'b1, it.data, it.buttons);
      CMD_PUSH: begin
        r = decode_access({STACK_PAGE, sp_img}, 1'b1, it.data, it.buttons);
        sp_img = sp_img - 8'd1;
      end
      CMD_POP: begin
        sp_img = sp_img + 8'd1;
        r = decode_access({STACK_PAGE, sp_img}, 1'b0, 8'h00, it.buttons);
      end
      CMD_LDSP:  sp_img = it.data;
      default: ;
    endcase
    r.stack_ptr = sp_img;
    return r;
  endfunction

  // reads of never-written RAM become writes and pops of never-written stack become pushes
  task automatic queue_access(logic [2:0] cmd, logic [15:0] addr, logic [7:0] data,
                              logic [7:0] buttons);
    in_item_t it;
    int idx;
    it.cmd = cmd;
    it.addr = addr;
    it.data = data;
    it.buttons = buttons;
    if (it.cmd == CMD_READ && it.addr <= ADDR_RAM_END && !gen_written[it.addr % RAM_WORDS])
      it.cmd = CMD_WRITE;
    if (it.cmd == CMD_POP && !gen_written[{STACK_PAGE, gen_sp + 8'd1} % RAM_WORDS])
      it.cmd = CMD_PUSH;
    case (it.cmd)
      CMD_WRITE: begin
        if (it.addr <= ADDR_RAM_END) begin
          idx = it.addr % RAM_WORDS;
          gen_written[idx] = 1'b1;
          recent_idx[recent_ptr] = idx[10:0];
          recent_ptr = (recent_ptr + 1) % 16;
        end
      end
      CMD_PUSH: begin
        gen_written[{STACK_PAGE, gen_sp} % RAM_WORDS] = 1'b1;
        gen_sp = gen_sp - 8'd1;
      end
      CMD_POP:  gen_sp = gen_sp + 8'd1;
      CMD_LDSP: gen_sp = it.data;
      default: ;
    endcase
    if (it.cmd <= CMD_LDSP) bus_items++;
    pending_accesses.push_back(it);
  endtask

  function automatic void check_field(string fname, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, fname, want, got);
      mismatches++;
    end
  endfunction

  initial begin : stimulus
    int n;
    logic [15:0] a;
    // directed corners
    queue_access(CMD_WRITE, 16'h0000, 8'h00, 8'h00);
    queue_access(CMD_WRITE, ADDR_RAM_END, 8'hFF, 8'hFF);
    queue_access(CMD_READ, 16'h0800, 8'hFF, 8'h00);
    queue_access(CMD_READ, 16'h07FF, 8'h00, 8'hFF);
    queue_access(CMD_PUSH, 16'hFFFF, 8'hA5, 8'h00);
    queue_access(CMD_POP, 16'h0000, 8'h00, 8'h00);
    queue_access(CMD_LDSP, 16'h0000, 8'hFF, 8'h00);
    queue_access(CMD_PUSH, 16'h0000, 8'h3C, 8'h00);
    queue_access(CMD_POP, 16'hFFFF, 8'hFF, 8'hFF);
    queue_access(CMD_WRITE, ADDR_PPU_BASE, 8'h12, 8'h00);
    queue_access(CMD_READ, ADDR_PPU_END, 8'h00, 8'h00);
    queue_access(CMD_WRITE, ADDR_DMA, 8'hFF, 8'h00);
    queue_access(CMD_READ, ADDR_DMA, 8'h00, 8'h00);
    queue_access(CMD_WRITE, ADDR_APU_STATUS, 8'h55, 8'h00);
    queue_access(CMD_READ, ADDR_APU_STATUS, 8'h00, 8'h00);
    queue_access(CMD_WRITE, ADDR_CTRL1, 8'h01, 8'hA5);
    queue_access(CMD_READ, ADDR_CTRL1, 8'h00, 8'h00);
    queue_access(CMD_WRITE, ADDR_CTRL1, 8'hFE, 8'hFF);
    queue_access(CMD_READ, ADDR_CTRL1, 8'h00, 8'h00);
    queue_access(CMD_WRITE, ADDR_CTRL2, 8'hAA, 8'h00);
    queue_access(CMD_READ, ADDR_CTRL2, 8'h00, 8'h00);
    queue_access(CMD_WRITE, 16'h4000, 8'h01, 8'h00);
    queue_access(CMD_READ, 16'h4013, 8'h00, 8'h00);
    queue_access(CMD_READ, ADDR_TEST_BASE, 8'h00, 8'h00);
    queue_access(CMD_WRITE, ADDR_TEST_END, 8'h80, 8'h00);
    queue_access(CMD_READ, ADDR_MAPPER, 8'h00, 8'h00);
    queue_access(CMD_WRITE, 16'hFFFF, 8'h7E, 8'h00);
    queue_access(CMD_SPARE_LAST, 16'hFFFF, 8'hFF, 8'hFF);

    while (bus_items < ITEM_COUNT) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          if ($urandom_range(0, 9) < 4)
            queue_access(CMD_WRITE, {3'b000, 2'($urandom), 11'($urandom)}, 8'($urandom),
                         8'($urandom));
          else
            queue_access(CMD_READ, {3'b000, 2'($urandom), recent_idx[$urandom_range(0, 15)]},
                         8'($urandom), 8'($urandom));
        end
        3, 4: begin
          n = $urandom_range(1, 6);
          if ($urandom_range(0, 3) == 0)
            queue_access(CMD_LDSP, 16'($urandom), 8'($urandom), 8'($urandom));
          repeat (n) queue_access(CMD_PUSH, 16'($urandom), 8'($urandom), 8'($urandom));
          repeat (n) queue_access(CMD_POP, 16'($urandom), 8'($urandom), 8'($urandom));
        end
        5: begin
          queue_access(CMD_WRITE, ADDR_CTRL1, {7'($urandom), 1'b1}, 8'($urandom));
          repeat ($urandom_range(1, 9)) begin
            if ($urandom_range(0, 7) == 0)
              queue_access(CMD_WRITE, ADDR_CTRL1, {7'($urandom), 1'b0}, 8'($urandom));
            queue_access(CMD_READ, ADDR_CTRL1, 8'($urandom), 8'($urandom));
          end
        end
        6, 7: begin
          case ($urandom_range(0, 3))
            0: a = 16'($urandom);
            1: a = 16'h4000 + 16'($urandom_range(0, 31));
            2: a = ADDR_PPU_BASE + 16'($urandom_range(0, 16'h1FFF));
            default: a = 16'($urandom_range(16'h4020, 16'hFFFF));
          endcase
          queue_access($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, a, 8'($urandom),
                       8'($urandom));
        end
        8: queue_access(CMD_LDSP, 16'($urandom), 8'($urandom), 8'($urandom));
        default: queue_access(3'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
      endcase
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_accesses.size() != 0 || start || predicted_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    $display("checked %0d results: %0d ram or stack, %0d controller 1, %0d other targets",
             results_seen, ram_results, pad_results, results_seen - ram_results - pad_results);
    $display("%0d field mismatches over directed corners and random bus traffic", mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) predicted_results.push_back(predict_bus_access(in_item));
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          start <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_accesses.size() != 0) begin
          in_item <= pending_accesses.pop_front();
          start <= 1'b1;
          if ($urandom_range(0, 63) == 0) no_gaps <= !no_gaps;
          gap_left <= no_gaps ? 0 : $urandom_range(0, 5);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n && out_valid) begin
      if (predicted_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got %p", $time, out_item);
        mismatches++;
      end else begin
        want = predicted_results.pop_front();
        check_field("target", want.target, out_item.target);
        check_field("read_data", want.read_data, out_item.read_data);
        check_field("fwd_addr", want.fwd_addr, out_item.fwd_addr);
        check_field("fwd_data", want.fwd_data, out_item.fwd_data);
        check_field("fwd_write", want.fwd_write, out_item.fwd_write);
        check_field("dma_start", want.dma_start, out_item.dma_start);
        check_field("dma_base", want.dma_base, out_item.dma_base);
        check_field("stack_ptr", want.stack_ptr, out_item.stack_ptr);
        results_seen++;
        if (want.target == TGT_RAM) ram_results++;
        if (want.target == TGT_CTRL1) pad_results++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timed out, %0d results outstanding", $time, predicted_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

// ===== console_cpu_bus_decoder.f =====
hdl/cbd_pkg.sv
hdl/console_cpu_bus_decoder.sv
tb/tb_top.sv
